// ===== rtl/lru_frame_replacer_assert.svh =====
// assertion macros shared by the lru frame replacer modules
`ifndef LRU_FRAME_REPLACER_ASSERT_SVH
`define LRU_FRAME_REPLACER_ASSERT_SVH

// expression holds at every clock edge outside reset
`define LFR_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("lru frame replacer: invariant violated");

// consequent holds in the cycle after the antecedent
`define LFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lru frame replacer: sequence violated");

`endif

// ===== rtl/lfr_pkg.sv =====
// types and constants of the lru frame replacer
`timescale 1ns / 1ps

package lfr_pkg;

   // default number of buffer frames
   localparam int FRAMES_DEFAULT = 64;

   // request opcodes
   typedef enum logic [1:0] {
      OP_VICTIM = 2'd0,
      OP_PIN    = 2'd1,
      OP_UNPIN  = 2'd2
   } opcode_type;

   // request beat
   typedef struct packed {
      logic [1:0] opcode;
      logic [5:0] frame_number;
   } req_payload_type;

   // result beat
   typedef struct packed {
      logic       victim_found;
      logic [5:0] victim_frame;
      logic [6:0] evictable_count;
   } rsp_payload_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic clear;
      logic load;
      logic exec;
   } ctrl_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic clear_last;
   } dp_status_type;

endpackage

// ===== rtl/lfr_ctrl.sv =====
// controller state machine of the lru frame replacer
`timescale 1ns / 1ps
`include "lru_frame_replacer_assert.svh"

module lfr_ctrl
   import lfr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   output ctrl_cmd_type  cmd,
   input  dp_status_type status
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   // next state: clearing sweep, then load / execute per request
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      busy_in = (state_in != ST_IDLE);
   end

   // state and registered busy
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         busy_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   // commands to the datapath
   always_comb begin
      cmd.clear = (state_ff == ST_CLEAR);
      cmd.load  = (state_ff == ST_IDLE) && start;
      cmd.exec  = (state_ff == ST_EXEC);
   end

   assign busy = busy_ff;

   `LFR_ASSERT_ALWAYS(a_busy_tracks_state, clock, reset, busy_ff == (state_ff != ST_IDLE))
   `LFR_ASSERT_NEXT(a_load_then_exec, clock, reset, cmd.load, cmd.exec)
   `LFR_ASSERT_NEXT(a_exec_single_cycle, clock, reset, cmd.exec, !cmd.exec)

endmodule

// ===== rtl/lfr_datapath.sv =====
// linked-list datapath of the lru frame replacer
`timescale 1ns / 1ps
`include "lru_frame_replacer_assert.svh"

module lfr_datapath
   import lfr_pkg::*;
#(
   parameter int FRAMES = FRAMES_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  ctrl_cmd_type    cmd,
   output dp_status_type   status,
   input  req_payload_type req_payload,
   output logic            rsp_strobe,
   output rsp_payload_type rsp_payload
);

   localparam int FIDX_W = $clog2(FRAMES);
   localparam int CNT_W  = $clog2(FRAMES + 1);

   // per-frame memories: listed mark, next (older) and prev (newer) links
   logic              mark_mem [FRAMES];
   logic [FIDX_W-1:0] next_mem [FRAMES];
   logic [FIDX_W-1:0] prev_mem [FRAMES];

   logic [FIDX_W-1:0] clear_cnt_ff;
   logic [FIDX_W-1:0] head_ff, head_in;
   logic [FIDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0]  len_ff, len_in;

   logic [1:0]        opcode_ff;
   logic [FIDX_W-1:0] fidx_ff;
   logic              fvalid_ff;
   logic              mark_rd_ff;
   logic [FIDX_W-1:0] next_rd_ff;
   logic [FIDX_W-1:0] prev_rd_ff;

   logic              rsp_strobe_ff;
   rsp_payload_type   rsp_payload_ff, rsp_payload_in;

   logic [FIDX_W-1:0] req_fidx;
   logic [FIDX_W-1:0] raddr;

   logic              mark_we, mark_wdata;
   logic [FIDX_W-1:0] mark_waddr;
   logic              next_we;
   logic [FIDX_W-1:0] next_waddr, next_wdata;
   logic              prev_we;
   logic [FIDX_W-1:0] prev_waddr, prev_wdata;

   logic              is_head, is_tail;

   // read address: tail for victim, requested frame otherwise
   assign req_fidx = FIDX_W'(req_payload.frame_number);
   assign raddr    = (req_payload.opcode == OP_VICTIM) ? tail_ff : req_fidx;

   // clearing sweep over the mark memory after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
      end else if (cmd.clear) begin
         clear_cnt_ff <= clear_cnt_ff + 1'b1;
      end
   end
   assign status.clear_last = (clear_cnt_ff == FIDX_W'(FRAMES - 1));

   // capture the request beat
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         opcode_ff <= req_payload.opcode;
         fidx_ff   <= req_fidx;
         fvalid_ff <= (32'(req_payload.frame_number) < FRAMES);
      end
   end

   assign is_head = (fidx_ff == head_ff);
   assign is_tail = (fidx_ff == tail_ff);

   // list update and result for the captured request
   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      len_in         = len_ff;
      mark_we        = 1'b0;
      mark_waddr     = fidx_ff;
      mark_wdata     = 1'b0;
      next_we        = 1'b0;
      next_waddr     = fidx_ff;
      next_wdata     = head_ff;
      prev_we        = 1'b0;
      prev_waddr     = head_ff;
      prev_wdata     = fidx_ff;
      rsp_payload_in = '0;

      if (cmd.clear) begin
         mark_we    = 1'b1;
         mark_waddr = clear_cnt_ff;
      end else if (cmd.exec) begin
         unique case (opcode_ff)
            OP_VICTIM: begin
               // take the tail, its newer neighbour becomes the tail
               if (len_ff != '0) begin
                  mark_we                     = 1'b1;
                  mark_waddr                  = tail_ff;
                  tail_in                     = prev_rd_ff;
                  len_in                      = len_ff - 1'b1;
                  rsp_payload_in.victim_found = 1'b1;
                  rsp_payload_in.victim_frame = 6'(tail_ff);
               end
            end
            OP_PIN: begin
               // unlink a listed frame
               if (fvalid_ff && mark_rd_ff) begin
                  mark_we = 1'b1;
                  len_in  = len_ff - 1'b1;
                  if (is_head && !is_tail) begin
                     head_in = next_rd_ff;
                  end else if (is_tail && !is_head) begin
                     tail_in = prev_rd_ff;
                  end else if (!is_head && !is_tail) begin
                     next_we    = 1'b1;
                     next_waddr = prev_rd_ff;
                     next_wdata = next_rd_ff;
                     prev_we    = 1'b1;
                     prev_waddr = next_rd_ff;
                     prev_wdata = prev_rd_ff;
                  end
               end
            end
            OP_UNPIN: begin
               // link an absent frame in front of the head
               if (fvalid_ff && !mark_rd_ff && len_ff != CNT_W'(FRAMES)) begin
                  mark_we    = 1'b1;
                  mark_wdata = 1'b1;
                  next_we    = 1'b1;
                  prev_we    = (len_ff != '0);
                  head_in    = fidx_ff;
                  if (len_ff == '0) tail_in = fidx_ff;
                  len_in     = len_ff + 1'b1;
               end
            end
            default: begin
               // unused opcode leaves the list alone
            end
         endcase
         rsp_payload_in.evictable_count = 7'(len_in);
      end
   end

   // list control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         len_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         len_ff  <= len_in;
      end
   end

   // mark memory
   always_ff @(posedge clock) begin
      if (mark_we) mark_mem[mark_waddr] <= mark_wdata;
      if (cmd.load) mark_rd_ff <= mark_mem[raddr];
   end

   // next link memory
   always_ff @(posedge clock) begin
      if (next_we) next_mem[next_waddr] <= next_wdata;
      if (cmd.load) next_rd_ff <= next_mem[raddr];
   end

   // prev link memory
   always_ff @(posedge clock) begin
      if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
      if (cmd.load) prev_rd_ff <= prev_mem[raddr];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.exec;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_payload_ff;

   `LFR_ASSERT_ALWAYS(a_len_bound, clock, reset, len_ff <= CNT_W'(FRAMES))
   `LFR_ASSERT_NEXT(a_exec_gives_beat, clock, reset, cmd.exec, rsp_strobe_ff)
   `LFR_ASSERT_NEXT(a_len_only_on_exec, clock, reset, !cmd.exec, $stable(len_ff))

endmodule

// ===== rtl/lru_frame_replacer.sv =====
// top level of the lru frame replacer
//
//   channel   ports                         beat moves when
//   request   start, busy, req_payload      start high and busy low
//   result    rsp_strobe, rsp_payload       rsp_strobe high (one cycle)
//
// Each request first reads the mark and link memories at the frame (or the
// tail for a victim), then relinks the list and registers the result.
// The result beat shows in the cycle after the relink, while the next request
// can be taken. After reset the mark memory is cleared one entry a cycle, with
// busy high. The receiver cannot stall; results are never held.
`timescale 1ns / 1ps

module lru_frame_replacer
   import lfr_pkg::*;
#(
   parameter int FRAMES = FRAMES_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_payload_type req_payload,
   output logic            rsp_strobe,
   output rsp_payload_type rsp_payload
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // controller
   lfr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   // datapath
   lfr_datapath #(
      .FRAMES (FRAMES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== sim/tb_lru_frame_replacer.sv =====
// self-checking testbench of the lru frame replacer with a recency-list scoreboard
`timescale 1ns / 1ps

import lfr_pkg::*;

// tracks the evictable list and the result beats that it predicts
class replacer_scoreboard;
   bit [5:0]        recency_q[$];
   bit              listed[64];
   rsp_payload_type due_q[$];
   int              errors;

   function new();
      errors = 0;
      foreach (listed[i]) listed[i] = 1'b0;
   endfunction

   // apply one accepted request beat and queue the result it causes
   function void note_request(req_payload_type beat);
      rsp_payload_type due;
      int              pos;
      due = '0;
      pos = -1;
      case (beat.opcode)
         OP_VICTIM: begin
            if (recency_q.size() > 0) begin
               due.victim_found = 1'b1;
               due.victim_frame = recency_q[recency_q.size() - 1];
               recency_q.delete(recency_q.size() - 1);
               listed[due.victim_frame] = 1'b0;
            end
         end
         OP_PIN: begin
            if (listed[beat.frame_number]) begin
               foreach (recency_q[i])
                  if (pos < 0 && recency_q[i] == beat.frame_number) pos = i;
               if (pos >= 0) recency_q.delete(pos);
               listed[beat.frame_number] = 1'b0;
            end
         end
         OP_UNPIN: begin
            // a frame already listed keeps its place
            if (!listed[beat.frame_number] && recency_q.size() < 64) begin
               recency_q.insert(0, beat.frame_number);
               listed[beat.frame_number] = 1'b1;
            end
         end
         default: ;
      endcase
      due.evictable_count = 7'(recency_q.size());
      due_q.push_back(due);
   endfunction

   // compare a result beat with the oldest prediction
   function void check_result(rsp_payload_type got);
      rsp_payload_type due;
      if (due_q.size() == 0) begin
         $display("%0t: unexpected result beat %h", $time, got);
         errors++;
         return;
      end
      due = due_q.pop_front();
      if (got.victim_found !== due.victim_found) begin
         $display("%0t: victim_found expected %0d actual %0d",
                  $time, due.victim_found, got.victim_found);
         errors++;
      end
      if (got.victim_frame !== due.victim_frame) begin
         $display("%0t: victim_frame expected %0d actual %0d",
                  $time, due.victim_frame, got.victim_frame);
         errors++;
      end
      if (got.evictable_count !== due.evictable_count) begin
         $display("%0t: evictable_count expected %0d actual %0d",
                  $time, due.evictable_count, got.evictable_count);
         errors++;
      end
   endfunction

   function int pending();
      return due_q.size();
   endfunction
endclass

module tb_lru_frame_replacer;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 16;

   logic            clock = 1'b0;
   logic            reset;
   logic            start;
   logic            busy;
   req_payload_type req_payload;
   logic            rsp_strobe;
   rsp_payload_type rsp_payload;

   replacer_scoreboard sb = new();
   int cycles = 0;
   int burst_left = 8;
   int gap_left = 0;

   lru_frame_replacer dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   always #4 clock = ~clock;

   // request beats accepted and result beats checked at the rising edge
   always @(posedge clock) begin
      if (!reset && start && !busy) sb.note_request(req_payload);
      if (!reset && rsp_strobe) sb.check_result(rsp_payload);
   end

   // run guard
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // present one beat, honouring the burst and gap pattern
   task automatic send_beat(input logic [1:0] op, input logic [5:0] frame);
      if (gap_left > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap_left - 1) @(negedge clock);
         gap_left = 0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_payload <= '{opcode: op, frame_number: frame};
      do @(posedge clock); while (busy);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
   endtask

   // lower start and wait for every predicted result
   task automatic hold_until_drained();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // weighted random requests
   task automatic send_mix(input int count, input int w_victim, input int w_pin,
                           input int w_unpin, input int w_unused, input int frame_hi);
      int         pick;
      logic [1:0] op;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, w_victim + w_pin + w_unpin + w_unused - 1);
         if (pick < w_victim) op = OP_VICTIM;
         else if (pick < w_victim + w_pin) op = OP_PIN;
         else if (pick < w_victim + w_pin + w_unpin) op = OP_UNPIN;
         else op = OP_UNUSED;
         send_beat(op, 6'($urandom_range(0, frame_hi)));
      end
   endtask

   // unpin every frame once in shuffled order, filling the list
   task automatic fill_list();
      int perm[64];
      int j;
      int tmp;
      foreach (perm[i]) perm[i] = i;
      for (int i = 63; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = perm[i];
         perm[i] = perm[j];
         perm[j] = tmp;
      end
      foreach (perm[i]) send_beat(OP_UNPIN, 6'(perm[i]));
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty list, unlisted pin, unused opcode, repeats, middle removal
      send_beat(OP_VICTIM, 6'd0);
      send_beat(OP_PIN, 6'd5);
      send_beat(OP_UNUSED, 6'd63);
      send_beat(OP_UNPIN, 6'd0);
      send_beat(OP_UNPIN, 6'd63);
      send_beat(OP_UNPIN, 6'd42);
      send_beat(OP_UNPIN, 6'd21);
      send_beat(OP_UNPIN, 6'd0);
      send_beat(OP_UNUSED, 6'd0);
      send_beat(OP_VICTIM, 6'd63);
      send_beat(OP_PIN, 6'd42);
      send_beat(OP_PIN, 6'd42);
      send_beat(OP_UNPIN, 6'd0);
      send_beat(OP_VICTIM, 6'd0);
      send_beat(OP_VICTIM, 6'd0);
      send_beat(OP_VICTIM, 6'd0);
      send_beat(OP_VICTIM, 6'd0);
      send_beat(OP_UNPIN, 6'd63);
      send_beat(OP_PIN, 6'd63);
      send_beat(OP_VICTIM, 6'd0);

      // random: few frames so hits and repeats are common
      send_mix(250, 25, 25, 45, 5, 7);
      // fill to capacity, pause, then hammer the full list
      fill_list();
      hold_until_drained();
      send_mix(30, 0, 0, 1, 0, 63);
      send_mix(200, 15, 15, 65, 5, 63);
      // drain past empty
      send_mix(120, 60, 20, 15, 5, 63);
      send_mix(250, 30, 30, 35, 5, 63);

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/lfr_pkg.sv
rtl/lfr_ctrl.sv
rtl/lfr_datapath.sv
rtl/lru_frame_replacer.sv
sim/tb_lru_frame_replacer.sv
